>>> rtl/asbx_pkg.sv
// shared types and gf(2^8) helpers for the algebraic s-box
package asbx_pkg;

    localparam int unsigned BYTE_W    = 8;
    // x^254 = x^2 * x^4 * ... * x^128, one square-and-multiply per stage
    localparam int unsigned INV_STEPS = 7;

    localparam logic [BYTE_W-1:0] RED_POLY  = 8'h1b;
    localparam logic [BYTE_W-1:0] AFF_CONST = 8'h63;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_INV = 1'b1
    } t_op;

    // word moving through the inversion chain
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] sq;
        logic [BYTE_W-1:0] acc;
    } t_step_data;

    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
        logic [BYTE_W-1:0] t;
        t = {a[BYTE_W-2:0], 1'b0};
        return a[BYTE_W-1] ? (t ^ RED_POLY) : t;
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        acc = '0;
        for (int i = BYTE_W - 1; i >= 0; i--) begin
            acc = gf_xtime(acc);
            if (a[i]) begin
                acc = acc ^ b;
            end
        end
        return acc;
    endfunction

    function automatic logic [BYTE_W-1:0] rotl(input logic [BYTE_W-1:0] v,
                                               input int unsigned k);
        logic [2*BYTE_W-1:0] d;
        d = {v, v} << k;
        return d[2*BYTE_W-1:BYTE_W];
    endfunction

    function automatic logic [BYTE_W-1:0] affine_fwd(input logic [BYTE_W-1:0] w);
        return w ^ rotl(w, 1) ^ rotl(w, 2) ^ rotl(w, 3) ^ rotl(w, 4) ^ AFF_CONST;
    endfunction

    function automatic logic [BYTE_W-1:0] affine_inv(input logic [BYTE_W-1:0] y);
        logic [BYTE_W-1:0] t;
        t = y ^ AFF_CONST;
        return rotl(t, 1) ^ rotl(t, 3) ^ rotl(t, 6);
    endfunction

endpackage

>>> rtl/aes_sbox_algebraic_core.sv
// top level: pipelined aes s-box and inverse s-box without a lookup table
// registered pipeline from the accepting edge to the edge that takes the result:
// input stage, seven square-and-multiply stages, output affine stage
// throughput: one word per cycle; busy stays low since every stage moves each cycle
// reset: synchronous active-low reset clears all stage valid bits; data is not reset
// the receiver cannot stall, so o_valid is a one-cycle strobe per word
module aes_sbox_algebraic_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_op,
    input  logic [7:0] i_value,
    output logic       o_valid,
    output logic [7:0] o_result
);

    localparam int unsigned NS = asbx_pkg::INV_STEPS;

    // input stage: inverse direction does its affine map before the field inverse
    logic                 r_in_valid;
    asbx_pkg::t_step_data r_in_data;
    asbx_pkg::t_step_data n_in_data;

    // chain of stage outputs; index 0 is the input stage
    logic                 chain_valid [NS+1];
    asbx_pkg::t_step_data chain_data  [NS+1];

    // output stage
    logic                        r_out_valid;
    logic [asbx_pkg::BYTE_W-1:0] r_result;
    logic [asbx_pkg::BYTE_W-1:0] n_result;
    asbx_pkg::t_step_data        last;

    // no stage ever holds, so a new word is taken every cycle
    assign busy = 1'b0;

    always_comb begin
        n_in_data.op  = asbx_pkg::t_op'(i_op);
        // acc starts at one so the first stage gives x^2
        n_in_data.acc = asbx_pkg::BYTE_W'(1);
        if (asbx_pkg::t_op'(i_op) == asbx_pkg::OP_INV) begin
            n_in_data.sq = asbx_pkg::affine_inv(i_value);
        end else begin
            n_in_data.sq = i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_data <= n_in_data;
    end

    assign chain_valid[0] = r_in_valid;
    assign chain_data[0]  = r_in_data;

    // x^254 by repeated squaring; zero falls out as zero with no special case
    for (genvar g = 0; g < NS; g++) begin : g_step
        asbx_inv_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    assign last = chain_data[NS];

    // forward direction applies its affine map after the field inverse
    always_comb begin
        if (last.op == asbx_pkg::OP_FWD) begin
            n_result = asbx_pkg::affine_fwd(last.acc);
        end else begin
            n_result = last.acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= chain_valid[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

endmodule

>>> rtl/asbx_inv_step.sv
// one square-and-multiply stage of the gf(2^8) inversion chain
module asbx_inv_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  asbx_pkg::t_step_data i_data,
    output logic                o_valid,
    output asbx_pkg::t_step_data o_data
);

    logic                 r_valid;
    asbx_pkg::t_step_data r_data;
    asbx_pkg::t_step_data n_data;
    logic [asbx_pkg::BYTE_W-1:0] sq_next;

    // squaring then multiply into the running product
    always_comb begin
        sq_next     = asbx_pkg::gf_mul(i_data.sq, i_data.sq);
        n_data.op   = i_data.op;
        n_data.sq   = sq_next;
        n_data.acc  = asbx_pkg::gf_mul(i_data.acc, sq_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> tb/tb_aes_sbox_algebraic_core.sv
// self-checking testbench for the algebraic aes s-box / inverse s-box core
module tb_aes_sbox_algebraic_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CLK_HALF    = 6;
    localparam int unsigned RST_CYCLES  = 11;
    // pipeline is 9 deep, drain a little longer than that
    localparam int unsigned DRAIN_WAIT  = 20;
    // ~2000 words plus sender gaps and drains, taken many times over
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SHOW_MAX    = 10;
    localparam int unsigned DIRECTED_N  = 20;

    // one word in flight: what went in and the byte that must come out
    typedef struct {
        asbx_pkg::t_op op;
        logic [7:0]    value;
        logic [7:0]    result;
    } t_sbox_word;

    // directed stimulus row, result typed in only for well-known table entries
    typedef struct {
        asbx_pkg::t_op op;
        logic [7:0]    value;
        bit            known;
        logic [7:0]    result;
    } t_stim_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_op;
    logic [7:0] i_value;
    logic       o_valid;
    logic [7:0] o_result;

    t_sbox_word  subst_due_q[$];
    t_sbox_word  head;
    int unsigned fail_cnt;
    int unsigned cycle_cnt;
    t_stim_row   directed_rows[DIRECTED_N];

    aes_sbox_algebraic_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_op     (i_op),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // gf(2^8) arithmetic mod x^8+x^4+x^3+x+1, written lsb-first
    // ---------------------------------------------------------------------
    function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] prod;
        logic [7:0] shifted;
        prod    = 8'h00;
        shifted = a;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                prod ^= shifted;
            end
            // multiply by x, fold the carry back with the low reduction bits
            shifted = {shifted[6:0], 1'b0} ^ (shifted[7] ? 8'h1b : 8'h00);
        end
        return prod;
    endfunction

    // a^254 by plain repeated multiplication; zero falls out as zero
    function automatic logic [7:0] field_recip(input logic [7:0] a);
        logic [7:0] pw;
        pw = a;
        for (int k = 1; k < 254; k++) begin
            pw = field_mul(pw, a);
        end
        return pw;
    endfunction

    // forward affine map, bit by bit: out[i] = w[i]^w[i+4]^w[i+5]^w[i+6]^w[i+7]
    function automatic logic [7:0] affine_out(input logic [7:0] w);
        logic [7:0] y;
        for (int i = 0; i < 8; i++) begin
            y[i] = w[i] ^ w[(i + 4) % 8] ^ w[(i + 5) % 8] ^ w[(i + 6) % 8]
                 ^ w[(i + 7) % 8];
        end
        return y ^ 8'h63;
    endfunction

    // inverse affine map on y^0x63: out[i] = t[i+2]^t[i+5]^t[i+7]
    function automatic logic [7:0] affine_back(input logic [7:0] y);
        logic [7:0] t;
        logic [7:0] w;
        t = y ^ 8'h63;
        for (int i = 0; i < 8; i++) begin
            w[i] = t[(i + 2) % 8] ^ t[(i + 5) % 8] ^ t[(i + 7) % 8];
        end
        return w;
    endfunction

    function automatic logic [7:0] sbox_predict(input asbx_pkg::t_op op,
                                                input logic [7:0] value);
        if (op == asbx_pkg::OP_FWD) begin
            return affine_out(field_recip(value));
        end
        return field_recip(affine_back(value));
    endfunction

    // ---------------------------------------------------------------------
    // driver side
    // ---------------------------------------------------------------------

    // present one word and hold it until the core takes it; start stays high
    task automatic send_byte(input asbx_pkg::t_op op, input logic [7:0] value,
                             input bit known, input logic [7:0] typed);
        t_sbox_word w;
        w.op     = op;
        w.value  = value;
        w.result = known ? typed : sbox_predict(op, value);
        start   <= 1'b1;
        i_op    <= op;
        i_value <= value;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
        subst_due_q.push_back(w);
    endtask

    // per-cycle chance of the sender going quiet after a word
    task automatic sender_gap(input int unsigned pct);
        if ($urandom_range(99) < pct) begin
            start <= 1'b0;
            do begin
                @(posedge i_clk);
            end while ($urandom_range(99) < pct);
        end
    endtask

    // sender holds off until every word in flight has come back
    task automatic drain_pipe();
        start <= 1'b0;
        while (subst_due_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic random_words(input int unsigned count, input int unsigned gap_pct);
        asbx_pkg::t_op op;
        logic [7:0]    value;
        for (int unsigned n = 0; n < count; n++) begin
            op = asbx_pkg::t_op'($urandom_range(1));
            // mostly uniform bytes, sometimes the zero-inverse corner cases
            case ($urandom_range(15))
                0:       value = (op == asbx_pkg::OP_FWD) ? 8'h00 : 8'h63;
                1:       value = 8'hff;
                default: value = 8'($urandom());
            endcase
            send_byte(op, value, 1'b0, 8'h00);
            sender_gap(gap_pct);
        end
    endtask

    initial begin
        // extremes, zero inverse both ways, and a few plain bit patterns
        directed_rows = '{
            '{asbx_pkg::OP_FWD, 8'h00, 1'b1, 8'h63},
            '{asbx_pkg::OP_FWD, 8'h01, 1'b1, 8'h7c},
            '{asbx_pkg::OP_FWD, 8'h80, 1'b1, 8'hcd},
            '{asbx_pkg::OP_FWD, 8'hff, 1'b1, 8'h16},
            '{asbx_pkg::OP_FWD, 8'h02, 1'b0, 8'h00},
            '{asbx_pkg::OP_FWD, 8'h7f, 1'b0, 8'h00},
            '{asbx_pkg::OP_FWD, 8'haa, 1'b0, 8'h00},
            '{asbx_pkg::OP_FWD, 8'h55, 1'b0, 8'h00},
            '{asbx_pkg::OP_FWD, 8'h53, 1'b0, 8'h00},
            '{asbx_pkg::OP_FWD, 8'h63, 1'b0, 8'h00},
            '{asbx_pkg::OP_INV, 8'h63, 1'b1, 8'h00},
            '{asbx_pkg::OP_INV, 8'h7c, 1'b1, 8'h01},
            '{asbx_pkg::OP_INV, 8'h00, 1'b1, 8'h52},
            '{asbx_pkg::OP_INV, 8'hff, 1'b1, 8'h7d},
            '{asbx_pkg::OP_INV, 8'h16, 1'b1, 8'hff},
            '{asbx_pkg::OP_INV, 8'h01, 1'b0, 8'h00},
            '{asbx_pkg::OP_INV, 8'h80, 1'b0, 8'h00},
            '{asbx_pkg::OP_INV, 8'haa, 1'b0, 8'h00},
            '{asbx_pkg::OP_INV, 8'h55, 1'b0, 8'h00},
            '{asbx_pkg::OP_INV, 8'hed, 1'b0, 8'h00}
        };

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_op    <= asbx_pkg::OP_FWD;
        i_value <= 8'h00;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows go in back to back
        for (int r = 0; r < DIRECTED_N; r++) begin
            send_byte(directed_rows[r].op, directed_rows[r].value,
                      directed_rows[r].known, directed_rows[r].result);
        end
        drain_pipe();

        // light sender idling, then heavy, then a solid stream
        random_words(700, 9);
        drain_pipe();
        random_words(700, 47);
        drain_pipe();
        random_words(600, 0);
        drain_pipe();

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0 && subst_due_q.size() == 0) begin
            $display("** aes_sbox_algebraic_core: PASSED **");
        end else begin
            $display("** aes_sbox_algebraic_core: FAILED **");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // result checker and watchdog; results cannot be held off, so every
    // strobe is taken at the edge that ends its cycle
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("** aes_sbox_algebraic_core: FAILED **");
            $finish;
        end else if (i_rst_n && o_valid === 1'b1) begin
            if (subst_due_q.size() == 0) begin
                if (fail_cnt < SHOW_MAX) begin
                    $display("[%0t] unexpected word: result=%02h", $realtime, o_result);
                end
                fail_cnt <= fail_cnt + 1;
            end else begin
                head = subst_due_q.pop_front();
                if (o_result !== head.result) begin
                    if (fail_cnt < SHOW_MAX) begin
                        $display("[%0t] mismatch op=%s value=%02h: exp %02h got %02h",
                                 $realtime, head.op.name(), head.value, head.result,
                                 o_result);
                    end
                    fail_cnt <= fail_cnt + 1;
                end
            end
        end
    end

    initial begin
        fail_cnt  = 0;
        cycle_cnt = 0;
    end

endmodule

>>> aes_sbox_algebraic_core.f
rtl/asbx_pkg.sv
rtl/asbx_inv_step.sv
rtl/aes_sbox_algebraic_core.sv
tb/tb_aes_sbox_algebraic_core.sv
